// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module tbt_checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== hdl/tbt_pkg.sv =====
// Package for the trilateration core: widths, depths, register indexes and word types.
// Depends on nothing; used by every module of the core.
package tbt_pkg;

  localparam int RW = 16;
  localparam int PW = 16;
  localparam int GW = 18;
  localparam int KW = 33;
  localparam int CW = 35;
  localparam int DW = 37;
  localparam int QW = 17;
  localparam int NW = DW + QW;

  localparam int MQ_DEPTH = 8;
  localparam int MQ_AW = 3;
  localparam int OQ_DEPTH = 32;
  localparam int OQ_AW = 5;
  localparam int SETTLE = 3;
  localparam int DIV_LAT = QW + 3;
  localparam int BACK_LAT = DIV_LAT + 4;

  localparam logic signed [RW-1:0] AX_RST = 16'sd0;
  localparam logic signed [RW-1:0] AY_RST = 16'sd0;
  localparam logic signed [RW-1:0] BX_RST = 16'sd160;
  localparam logic signed [RW-1:0] BY_RST = 16'sd0;
  localparam logic signed [RW-1:0] CX_RST = 16'sd0;
  localparam logic signed [RW-1:0] CY_RST = 16'sd160;

  localparam logic signed [PW-1:0] POS_MAX = 16'sh7FFF;
  localparam logic signed [PW-1:0] POS_MIN = 16'sh8000;
  localparam logic [QW-1:0] QLIM_POS = 17'd32767;
  localparam logic [QW-1:0] QLIM_NEG = 17'd32768;

  typedef enum logic [2:0] {
    REG_AX,
    REG_AY,
    REG_BX,
    REG_BY,
    REG_CX,
    REG_CY
  } reg_idx_t;

  typedef struct packed {
    logic signed [GW-1:0] a1;
    logic signed [GW-1:0] b1;
    logic signed [GW-1:0] a2;
    logic signed [GW-1:0] b2;
    logic signed [DW-1:0] det;
  } geom_t;

  typedef struct packed {
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] c2;
  } rhs_t;

  typedef struct packed {
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic degenerate;
    logic clipped;
  } result_t;

endpackage

// ===== hdl/tbt_front.sv =====
// Front end: beacon registers, derived geometry, and the range-squaring pipeline.
// Depends on tbt_pkg; feeds the back end with one right-hand-side word per item.
module tbt_front (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic [2:0] cfg_index,
  input  logic [tbt_pkg::RW-1:0] cfg_data,
  output logic cfg_ready,
  input  logic push,
  input  logic [tbt_pkg::RW-1:0] range_a,
  input  logic [tbt_pkg::RW-1:0] range_b,
  input  logic [tbt_pkg::RW-1:0] range_c,
  output logic full,
  input  logic mq_pop,
  output logic rhs_valid,
  output tbt_pkg::rhs_t rhs,
  output tbt_pkg::geom_t geom
);

  logic signed [tbt_pkg::RW-1:0] ax, ay, bx, by, cx, cy;
  logic signed [tbt_pkg::RW:0] dbx, dby, dcx, dcy;
  logic signed [31:0] sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy;
  logic signed [tbt_pkg::GW-1:0] a1, b1, a2, b2;
  logic signed [tbt_pkg::KW-1:0] kb, kc;
  logic signed [tbt_pkg::DW-1:0] pd1, pd2, det;
  logic [1:0] settle;
  logic [tbt_pkg::MQ_AW:0] credit, credit_next;
  logic accept;
  logic v0, v1, v2;
  logic [tbt_pkg::RW-1:0] ra_q, rb_q, rc_q;
  logic [31:0] ra2, rb2, rc2;
  logic signed [tbt_pkg::CW-1:0] c1, c2;

  assign cfg_ready = 1'b1;
  assign full = (credit == '0) || (settle != 2'd0);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= tbt_pkg::AX_RST;
      ay <= tbt_pkg::AY_RST;
      bx <= tbt_pkg::BX_RST;
      by <= tbt_pkg::BY_RST;
      cx <= tbt_pkg::CX_RST;
      cy <= tbt_pkg::CY_RST;
      settle <= 2'(tbt_pkg::SETTLE);
    end else if (cfg_valid && cfg_ready) begin
      settle <= 2'(tbt_pkg::SETTLE);
      case (tbt_pkg::reg_idx_t'(cfg_index))
        tbt_pkg::REG_AX: ax <= cfg_data;
        tbt_pkg::REG_AY: ay <= cfg_data;
        tbt_pkg::REG_BX: bx <= cfg_data;
        tbt_pkg::REG_BY: by <= cfg_data;
        tbt_pkg::REG_CX: cx <= cfg_data;
        tbt_pkg::REG_CY: cy <= cfg_data;
        default: ;
      endcase
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // Geometry is registered in stages behind the beacon registers; input is held off meanwhile.
  always_ff @(posedge clk) begin
    dbx <= 17'(bx) - 17'(ax);
    dby <= 17'(by) - 17'(ay);
    dcx <= 17'(cx) - 17'(ax);
    dcy <= 17'(cy) - 17'(ay);
    sq_ax <= 32'(ax) * 32'(ax);
    sq_ay <= 32'(ay) * 32'(ay);
    sq_bx <= 32'(bx) * 32'(bx);
    sq_by <= 32'(by) * 32'(by);
    sq_cx <= 32'(cx) * 32'(cx);
    sq_cy <= 32'(cy) * 32'(cy);
    a1 <= {dbx, 1'b0};
    b1 <= {dby, 1'b0};
    a2 <= {dcx, 1'b0};
    b2 <= {dcy, 1'b0};
    kb <= tbt_pkg::KW'(sq_bx) + tbt_pkg::KW'(sq_by) - tbt_pkg::KW'(sq_ax)
          - tbt_pkg::KW'(sq_ay);
    kc <= tbt_pkg::KW'(sq_cx) + tbt_pkg::KW'(sq_cy) - tbt_pkg::KW'(sq_ax)
          - tbt_pkg::KW'(sq_ay);
    pd1 <= tbt_pkg::DW'(dbx) * tbt_pkg::DW'(dcy);
    pd2 <= tbt_pkg::DW'(dcx) * tbt_pkg::DW'(dby);
    det <= (pd1 - pd2) <<< 2;
  end

  assign geom = '{a1: a1, b1: b1, a2: a2, b2: b2, det: det};

  always_comb begin
    credit_next = credit;
    if (accept) begin
      credit_next = credit_next - 1'b1;
    end
    if (mq_pop) begin
      credit_next = credit_next + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= (tbt_pkg::MQ_AW+1)'(tbt_pkg::MQ_DEPTH);
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      credit <= credit_next;
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ra_q <= range_a;
      rb_q <= range_b;
      rc_q <= range_c;
    end
    ra2 <= 32'(ra_q) * 32'(ra_q);
    rb2 <= 32'(rb_q) * 32'(rb_q);
    rc2 <= 32'(rc_q) * 32'(rc_q);
    c1 <= $signed({3'b000, ra2}) - $signed({3'b000, rb2}) + tbt_pkg::CW'(kb);
    c2 <= $signed({3'b000, ra2}) - $signed({3'b000, rc2}) + tbt_pkg::CW'(kc);
  end

  assign rhs_valid = v2;
  assign rhs = '{c1: c1, c2: c2};

endmodule

// ===== hdl/tbt_div.sv =====
// Pipelined signed divider that truncates toward zero and saturates to 16 bits.
// Depends on tbt_pkg; one quotient bit is resolved per stage.
module tbt_div (
  input  logic clk,
  input  logic signed [tbt_pkg::NW-1:0] num,
  input  logic signed [tbt_pkg::DW-1:0] den,
  output logic signed [tbt_pkg::PW-1:0] quo,
  output logic clip
);

  logic [tbt_pkg::NW-1:0] nmag;
  logic [tbt_pkg::DW-1:0] dmag;
  logic neg_a;
  logic [tbt_pkg::NW-1:0] rem [tbt_pkg::QW];
  logic [tbt_pkg::DW-1:0] dv [tbt_pkg::QW];
  logic ng [tbt_pkg::QW+1];
  logic ov [tbt_pkg::QW+1];
  logic [tbt_pkg::QW-1:0] qt [tbt_pkg::QW+1];
  logic [tbt_pkg::QW-1:0] q;

  always_ff @(posedge clk) begin
    nmag <= num[tbt_pkg::NW-1] ? tbt_pkg::NW'(-num) : tbt_pkg::NW'(num);
    dmag <= den[tbt_pkg::DW-1] ? tbt_pkg::DW'(-den) : tbt_pkg::DW'(den);
    neg_a <= num[tbt_pkg::NW-1] ^ den[tbt_pkg::DW-1];
  end

  // A numerator at or above the divisor times 2^QW cannot fit the output range.
  always_ff @(posedge clk) begin
    rem[0] <= nmag;
    dv[0] <= dmag;
    ng[0] <= neg_a;
    ov[0] <= nmag >= {dmag, {tbt_pkg::QW{1'b0}}};
    qt[0] <= '0;
  end

  for (genvar i = 0; i < tbt_pkg::QW; i++) begin : g_stage
    logic [tbt_pkg::NW-1:0] shifted;
    logic ge;
    assign shifted = tbt_pkg::NW'(dv[i]) << (tbt_pkg::QW - 1 - i);
    assign ge = rem[i] >= shifted;
    always_ff @(posedge clk) begin
      ng[i+1] <= ng[i];
      ov[i+1] <= ov[i];
      qt[i+1] <= qt[i] | (ge ? (tbt_pkg::QW'(1) << (tbt_pkg::QW - 1 - i)) : '0);
    end
    if (i < tbt_pkg::QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[i+1] <= ge ? rem[i] - shifted : rem[i];
        dv[i+1] <= dv[i];
      end
    end
  end

  assign q = qt[tbt_pkg::QW];

  always_ff @(posedge clk) begin
    if (ov[tbt_pkg::QW]) begin
      clip <= 1'b1;
      quo <= ng[tbt_pkg::QW] ? tbt_pkg::POS_MIN : tbt_pkg::POS_MAX;
    end else if (!ng[tbt_pkg::QW]) begin
      clip <= q > tbt_pkg::QLIM_POS;
      quo <= (q > tbt_pkg::QLIM_POS) ? tbt_pkg::POS_MAX : tbt_pkg::PW'(q);
    end else begin
      clip <= q > tbt_pkg::QLIM_NEG;
      quo <= (q > tbt_pkg::QLIM_NEG) ? tbt_pkg::POS_MIN
             : tbt_pkg::PW'(tbt_pkg::QW'(0) - q);
    end
  end

endmodule

// ===== hdl/tbt_back.sv =====
// Back end: queue of right-hand-side words, Cramer products and the two dividers.
// Depends on tbt_pkg and tbt_div; issues only when the result queue has room.
module tbt_back (
  input  logic clk,
  input  logic rst,
  input  logic rhs_valid,
  input  tbt_pkg::rhs_t rhs,
  input  tbt_pkg::geom_t geom,
  output logic mq_pop,
  input  logic oq_pop,
  output logic res_valid,
  output tbt_pkg::result_t res
);

  tbt_pkg::rhs_t mq [tbt_pkg::MQ_DEPTH];
  logic [tbt_pkg::MQ_AW-1:0] wr_ptr, rd_ptr;
  logic [tbt_pkg::MQ_AW:0] count, count_next;
  logic [tbt_pkg::OQ_AW:0] credit, credit_next;
  logic [tbt_pkg::BACK_LAT-1:0] vsh;
  tbt_pkg::rhs_t s0;
  logic signed [tbt_pkg::NW-1:0] pxa, pxb, pya, pyb, nx, ny;
  logic signed [tbt_pkg::PW-1:0] qx, qy;
  logic clip_x, clip_y, degen;

  assign mq_pop = (count != '0) && (credit != '0);

  always_comb begin
    count_next = count;
    credit_next = credit;
    if (rhs_valid) begin
      count_next = count_next + 1'b1;
    end
    if (mq_pop) begin
      count_next = count_next - 1'b1;
      credit_next = credit_next - 1'b1;
    end
    if (oq_pop) begin
      credit_next = credit_next + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      credit <= (tbt_pkg::OQ_AW+1)'(tbt_pkg::OQ_DEPTH);
      vsh <= '0;
    end else begin
      count <= count_next;
      credit <= credit_next;
      vsh <= {vsh[tbt_pkg::BACK_LAT-2:0], mq_pop};
      if (rhs_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (mq_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rhs_valid) begin
      mq[wr_ptr] <= rhs;
    end
    s0 <= mq[rd_ptr];
    pxa <= tbt_pkg::NW'(s0.c1) * tbt_pkg::NW'(geom.b2);
    pxb <= tbt_pkg::NW'(s0.c2) * tbt_pkg::NW'(geom.b1);
    pya <= tbt_pkg::NW'(geom.a1) * tbt_pkg::NW'(s0.c2);
    pyb <= tbt_pkg::NW'(geom.a2) * tbt_pkg::NW'(s0.c1);
    nx <= pxa - pxb;
    ny <= pya - pyb;
  end

  tbt_div u_div_x (.clk(clk), .num(nx), .den(geom.det), .quo(qx), .clip(clip_x));
  tbt_div u_div_y (.clk(clk), .num(ny), .den(geom.det), .quo(qy), .clip(clip_y));

  assign degen = (geom.det == '0);

  always_ff @(posedge clk) begin
    res.pos_x <= degen ? '0 : qx;
    res.pos_y <= degen ? '0 : qy;
    res.degenerate <= degen;
    res.clipped <= !degen && (clip_x || clip_y);
  end

  assign res_valid = vsh[tbt_pkg::BACK_LAT-1];

endmodule

// ===== hdl/tbt_outq.sv =====
// Result queue that holds finished words until the consumer pops them.
// Depends on tbt_pkg; reports each pop back to the issue credit in the back end.
module tbt_outq (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  tbt_pkg::result_t wr_data,
  input  logic pop,
  output logic empty,
  output tbt_pkg::result_t rd_data,
  output logic pop_ok
);

  tbt_pkg::result_t mem [tbt_pkg::OQ_DEPTH];
  logic [tbt_pkg::OQ_AW-1:0] wr_ptr, rd_ptr;
  logic [tbt_pkg::OQ_AW:0] count, count_next;

  assign empty = (count == '0);
  assign pop_ok = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr_valid) begin
      count_next = count_next + 1'b1;
    end
    if (pop_ok) begin
      count_next = count_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (wr_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== hdl/three_beacon_trilateration_core.sv =====
// Three-beacon trilateration core; uses tbt_pkg, tbt_front, tbt_back and tbt_outq.
// Throughput is one word per cycle while full is low, set by the fully pipelined 17-stage dividers.
// Input is held off after each register write while the geometry settles.
// Synchronous reset restores the default beacons, empties both queues and holds
// input off while the geometry settles.
module three_beacon_trilateration_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [tbt_pkg::RW-1:0] cfg_data,
  input  logic push,
  output logic full,
  input  logic [tbt_pkg::RW-1:0] range_a,
  input  logic [tbt_pkg::RW-1:0] range_b,
  input  logic [tbt_pkg::RW-1:0] range_c,
  output logic empty,
  input  logic pop,
  output logic signed [tbt_pkg::PW-1:0] pos_x,
  output logic signed [tbt_pkg::PW-1:0] pos_y,
  output logic degenerate,
  output logic clipped
);

  logic mq_pop, rhs_valid, res_valid, oq_pop;
  tbt_pkg::rhs_t rhs;
  tbt_pkg::geom_t geom;
  tbt_pkg::result_t res, head;

  tbt_front u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cfg_ready(cfg_ready),
    .push(push), .range_a(range_a), .range_b(range_b), .range_c(range_c),
    .full(full), .mq_pop(mq_pop),
    .rhs_valid(rhs_valid), .rhs(rhs), .geom(geom)
  );

  tbt_back u_back (
    .clk(clk), .rst(rst),
    .rhs_valid(rhs_valid), .rhs(rhs), .geom(geom),
    .mq_pop(mq_pop), .oq_pop(oq_pop),
    .res_valid(res_valid), .res(res)
  );

  tbt_outq u_outq (
    .clk(clk), .rst(rst),
    .wr_valid(res_valid), .wr_data(res),
    .pop(pop), .empty(empty), .rd_data(head), .pop_ok(oq_pop)
  );

  assign pos_x = head.pos_x;
  assign pos_y = head.pos_y;
  assign degenerate = head.degenerate;
  assign clipped = head.clipped;

endmodule

// ===== hdl/tbt_checker.sv =====
// Port-level checker for the trilateration core, bound to the top level.
// Depends on assert_macros.svh and tbt_pkg.
`include "assert_macros.svh"

module tbt_checker (
  input logic clk,
  input logic rst,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic signed [tbt_pkg::PW-1:0] pos_x,
  input logic signed [tbt_pkg::PW-1:0] pos_y,
  input logic degenerate,
  input logic clipped
);

  `ASSERT_IMPLY(a_degen_zero, clk, rst, !empty && degenerate, pos_x == '0 && pos_y == '0 && !clipped)
  `ASSERT_NEXT(a_cfg_holds_off, clk, rst, cfg_valid && cfg_ready, full)
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, empty)
  `ASSERT_NEXT(a_word_stays, clk, rst, !empty && !pop, !empty)

endmodule

bind three_beacon_trilateration_core tbt_checker u_tbt_checker (.*);

// ===== sim/trilat_checker.sv =====
// Checker for the trilateration core: tracks beacon writes, solves each range word
// and compares it with the result words. Depends on tbt_pkg.
module trilat_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [tbt_pkg::RW-1:0] cfg_data,
  input  logic push,
  input  logic full,
  input  logic [tbt_pkg::RW-1:0] range_a,
  input  logic [tbt_pkg::RW-1:0] range_b,
  input  logic [tbt_pkg::RW-1:0] range_c,
  input  logic empty,
  input  logic pop,
  input  logic signed [tbt_pkg::PW-1:0] pos_x,
  input  logic signed [tbt_pkg::PW-1:0] pos_y,
  input  logic degenerate,
  input  logic clipped,
  output int errors,
  output int pending
);

  logic signed [tbt_pkg::RW-1:0] beacon [6];
  tbt_pkg::result_t expected_fixes [$];

  function automatic logic signed [tbt_pkg::PW-1:0] clamp_pos(longint v, inout logic clip);
    if (v > 32767) begin
      clip = 1'b1;
      return tbt_pkg::POS_MAX;
    end
    if (v < -32768) begin
      clip = 1'b1;
      return tbt_pkg::POS_MIN;
    end
    return tbt_pkg::PW'(v);
  endfunction

  function automatic tbt_pkg::result_t solve_position(logic [tbt_pkg::RW-1:0] ra_w,
                                                      logic [tbt_pkg::RW-1:0] rb_w,
                                                      logic [tbt_pkg::RW-1:0] rc_w);
    longint ax, ay, bx, by, cx, cy, ra, rb, rc;
    longint a1, b1, a2, b2, na, c1, c2, det;
    tbt_pkg::result_t r;
    logic clip;
    ax = beacon[tbt_pkg::REG_AX]; ay = beacon[tbt_pkg::REG_AY];
    bx = beacon[tbt_pkg::REG_BX]; by = beacon[tbt_pkg::REG_BY];
    cx = beacon[tbt_pkg::REG_CX]; cy = beacon[tbt_pkg::REG_CY];
    ra = ra_w; rb = rb_w; rc = rc_w;
    a1 = 2 * (bx - ax);
    b1 = 2 * (by - ay);
    a2 = 2 * (cx - ax);
    b2 = 2 * (cy - ay);
    na = ax * ax + ay * ay;
    c1 = ra * ra - rb * rb + bx * bx + by * by - na;
    c2 = ra * ra - rc * rc + cx * cx + cy * cy - na;
    det = a1 * b2 - a2 * b1;
    clip = 1'b0;
    r = '0;
    if (det == 0) begin
      r.degenerate = 1'b1;
    end else begin
      r.pos_x = clamp_pos((c1 * b2 - c2 * b1) / det, clip);
      r.pos_y = clamp_pos((a1 * c2 - a2 * c1) / det, clip);
    end
    r.clipped = clip;
    return r;
  endfunction

  always @(posedge clk) begin
    tbt_pkg::result_t e;
    if (rst) begin
      beacon[tbt_pkg::REG_AX] <= tbt_pkg::AX_RST;
      beacon[tbt_pkg::REG_AY] <= tbt_pkg::AY_RST;
      beacon[tbt_pkg::REG_BX] <= tbt_pkg::BX_RST;
      beacon[tbt_pkg::REG_BY] <= tbt_pkg::BY_RST;
      beacon[tbt_pkg::REG_CX] <= tbt_pkg::CX_RST;
      beacon[tbt_pkg::REG_CY] <= tbt_pkg::CY_RST;
      expected_fixes.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= tbt_pkg::REG_CY) begin
        beacon[cfg_index] <= cfg_data;
      end
      if (push && !full) begin
        expected_fixes.push_back(solve_position(range_a, range_b, range_c));
      end
      if (pop && !empty) begin
        if (expected_fixes.size() == 0) begin
          $error("unexpected result word: pos_x %0d pos_y %0d", pos_x, pos_y);
          errors++;
        end else begin
          e = expected_fixes.pop_front();
          if (pos_x !== e.pos_x) begin
            $error("pos_x expected %0d actual %0d", e.pos_x, pos_x);
            errors++;
          end
          if (pos_y !== e.pos_y) begin
            $error("pos_y expected %0d actual %0d", e.pos_y, pos_y);
            errors++;
          end
          if (degenerate !== e.degenerate) begin
            $error("degenerate expected %0b actual %0b", e.degenerate, degenerate);
            errors++;
          end
          if (clipped !== e.clipped) begin
            $error("clipped expected %0b actual %0b", e.clipped, clipped);
            errors++;
          end
        end
      end
    end
    pending = expected_fixes.size();
  end
endmodule

// ===== sim/tb_three_beacon_trilateration_core.sv =====
// Testbench top for the trilateration core: drives beacon setups and range words
// with random gaps and stalls. Depends on tbt_pkg, trilat_checker and the core.
module tb_three_beacon_trilateration_core;

  localparam int LIMIT = 400000;
  localparam logic [2:0] UNUSED_IDX = 3'd6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [tbt_pkg::RW-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [tbt_pkg::RW-1:0] range_a = '0, range_b = '0, range_c = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [tbt_pkg::PW-1:0] pos_x, pos_y;
  logic degenerate, clipped;
  int errors, pending;
  int cycles = 0;
  int pop_hold = 0;
  logic signed [tbt_pkg::RW-1:0] geo [6];

  always #6 clk = ~clk;

  three_beacon_trilateration_core DUT (.*);
  trilat_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_three_beacon_trilateration_core: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if (cycles % 2000 < 1500) pop_hold <= pick_gap();
    end
  end

  task automatic send(logic [tbt_pkg::RW-1:0] ra, logic [tbt_pkg::RW-1:0] rb,
                      logic [tbt_pkg::RW-1:0] rc);
    int n;
    n = (cycles % 3000 < 600) ? 0 : pick_gap();
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(negedge clk);
    end
    push <= 1'b1;
    range_a <= ra;
    range_b <= rb;
    range_c <= rc;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [tbt_pkg::RW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_beacons();
    tbt_pkg::reg_idx_t r;
    for (int i = 0; i < 6; i++) begin
      r = tbt_pkg::reg_idx_t'(i);
      write_reg(r, geo[i]);
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [tbt_pkg::RW-1:0] true_range(int px, int py, int bx, int by);
    real d;
    int v;
    d = $sqrt(real'((px - bx) * (px - bx) + (py - by) * (py - by)));
    v = $rtoi(d) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return tbt_pkg::RW'(v);
  endfunction

  task automatic random_words(int count, int span);
    int px, py;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 80) begin
        px = int'($urandom_range(0, 2 * span)) - span;
        py = int'($urandom_range(0, 2 * span)) - span;
        send(true_range(px, py, geo[tbt_pkg::REG_AX], geo[tbt_pkg::REG_AY]),
             true_range(px, py, geo[tbt_pkg::REG_BX], geo[tbt_pkg::REG_BY]),
             true_range(px, py, geo[tbt_pkg::REG_CX], geo[tbt_pkg::REG_CY]));
      end else begin
        send(tbt_pkg::RW'($urandom), tbt_pkg::RW'($urandom), tbt_pkg::RW'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    geo[tbt_pkg::REG_AX] = 0; geo[tbt_pkg::REG_AY] = 0; geo[tbt_pkg::REG_BX] = 160;
    geo[tbt_pkg::REG_BY] = 0; geo[tbt_pkg::REG_CX] = 0; geo[tbt_pkg::REG_CY] = 160;
    send(0, 0, 0);
    send(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(16'hFFFF, 0, 0);
    send(0, 16'hFFFF, 0);
    send(0, 0, 16'hFFFF);
    send(113, 113, 113);
    send(80, 80, 80);
    send(16'h5555, 16'hAAAA, 16'h0F0F);
    send(16'hAAAA, 16'h5555, 16'hF0F0);
    random_words(60, 300);
    drain();

    geo[tbt_pkg::REG_AX] = -32768; geo[tbt_pkg::REG_AY] = -32768;
    geo[tbt_pkg::REG_BX] = 32767; geo[tbt_pkg::REG_BY] = -32768;
    geo[tbt_pkg::REG_CX] = -32768; geo[tbt_pkg::REG_CY] = 32767;
    load_beacons();
    send(0, 0, 0);
    send(16'hFFFF, 0, 16'hFFFF);
    send(0, 16'hFFFF, 16'hFFFF);
    send(16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    write_reg(UNUSED_IDX, 16'h1234);
    write_reg(UNUSED_IDX + 3'd1, 16'h4321);
    cfg_valid <= 1'b0;
    @(negedge clk);
    geo[tbt_pkg::REG_AX] = 0; geo[tbt_pkg::REG_AY] = 0; geo[tbt_pkg::REG_BX] = 16;
    geo[tbt_pkg::REG_BY] = 16; geo[tbt_pkg::REG_CX] = 32; geo[tbt_pkg::REG_CY] = 32;
    load_beacons();
    send(100, 200, 300);
    send(0, 0, 0);
    drain();

    geo[tbt_pkg::REG_AX] = 50; geo[tbt_pkg::REG_AY] = 50; geo[tbt_pkg::REG_BX] = 50;
    geo[tbt_pkg::REG_BY] = 50; geo[tbt_pkg::REG_CX] = 50; geo[tbt_pkg::REG_CY] = 50;
    load_beacons();
    send(1, 2, 3);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 6; i++) begin
        geo[i] = tbt_pkg::RW'(int'($urandom_range(0, 4000)) - 2000);
      end
      load_beacons();
      random_words(50, 2500);
      drain();
    end

    wait (pending == 0);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("tb_three_beacon_trilateration_core: PASS");
    end else begin
      $display("tb_three_beacon_trilateration_core: FAIL");
    end
    $finish;
  end
endmodule
